// ===== rtl/ostc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ostc_pkg: shared types and codes of the order-statistic count tree
// Word layouts of both channels, request and status codes, ALU flags.
// ---------------------------------------------------------------------------
package ostc_pkg;

  // Field widths fixed by the channel words
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned KEY_W    = 10;
  localparam int unsigned RANK_W   = 16;
  localparam int unsigned STATUS_W = 2;

  // Defaults for the top-level parameters
  localparam int unsigned KEY_BITS_DEF   = 10;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Request kinds
  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_FIND   = 2'd2;
  localparam logic [FUNC_W-1:0] FN_NOP    = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANK   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd3;

  // Input word
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [RANK_W-1:0] rank;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [KEY_W-1:0]    found_key;
    logic [STATUS_W-1:0] status;
  } out_word_t;

  // Flags of the shared add/subtract unit
  typedef struct packed {
    logic carry;  // carry out; for subtract, set when a >= b
    logic zero;   // result is zero
  } alu_flags_t;

endpackage : ostc_pkg
`default_nettype wire

// ===== rtl/ostc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ostc_ram: generic simple dual-port RAM
// One write port and one read port, registered read data, read-first.
// ---------------------------------------------------------------------------
module ostc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule : ostc_ram
`default_nettype wire

// ===== rtl/ostc_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ostc_alu: shared add/subtract and compare unit
// Computes a + b or a - b with carry and zero flags for the sequencer.
// ---------------------------------------------------------------------------
module ostc_alu #(
  parameter int unsigned W = 16
) (
  input  wire logic [W-1:0]            a_i,
  input  wire logic [W-1:0]            b_i,
  input  wire logic                    sub_i,
  output logic      [W-1:0]            sum_o,
  output ostc_pkg::alu_flags_t         flags_o
);

  import ostc_pkg::*;

  logic [W-1:0] b_op;
  logic [W:0]   full;

  // Two's complement subtract via inverted operand and carry in
  assign b_op = sub_i ? ~b_i : b_i;
  assign full = {1'b0, a_i} + {1'b0, b_op} + {{W{1'b0}}, sub_i};

  assign sum_o         = full[W-1:0];
  assign flags_o.carry = full[W];
  assign flags_o.zero  = (full[W-1:0] == '0);

endmodule : ostc_alu
`default_nettype wire

// ===== rtl/order_statistic_count_tree_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// order_statistic_count_tree_core: k-th smallest key over a count tree
// Multiset of keys kept as a binary tree of counts in one RAM.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_word_i) carries one request
//   word: insert a key, remove a key, or find the k-th smallest key. Every
//   request gives exactly one result word on the output channel
//   (out_valid_o / out_ready_i / out_word_o) with found_key and status.
//   Requests are handled one at a time; in_ready_o is high only while the
//   sequencer is idle. Each tree level passes through the shared adder and
//   the RAM's single read port. Insert and remove check a node and then
//   walk from the leaf up to the root; find checks the root total and then
//   descends from the root to a leaf; a rejected request or an unused
//   request kind goes straight on to its result.
//   The result sits in an output register; a new request is taken while it
//   waits. If the receiver stalls, a finished request holds in its last
//   step until the output register frees up.
//   After reset a clearing pass writes zero to all 2^(KEY_BITS+1) tree
//   nodes, one per cycle; no request is accepted until it ends.
// ---------------------------------------------------------------------------
module order_statistic_count_tree_core #(
  parameter int unsigned KEY_BITS   = ostc_pkg::KEY_BITS_DEF,
  parameter int unsigned COUNT_BITS = ostc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire ostc_pkg::in_word_t   in_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output ostc_pkg::out_word_t       out_word_o
);

  import ostc_pkg::*;

  localparam int unsigned NODE_W = KEY_BITS + 1;
  localparam int unsigned DEPTH  = 2 ** NODE_W;
  localparam int unsigned AW     = (COUNT_BITS > RANK_W) ? COUNT_BITS : RANK_W;
  localparam int unsigned LVL_W  = $clog2(KEY_BITS);

  localparam logic [NODE_W-1:0] ROOT     = NODE_W'(1);
  localparam logic [NODE_W-1:0] ROOT_LC  = NODE_W'(2);
  localparam logic [LVL_W-1:0]  LVL_LAST = LVL_W'(KEY_BITS - 1);

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_FIND  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [NODE_W-1:0]     clr_q, clr_d;
  logic [NODE_W-1:0]     node_q, node_d;
  logic [COUNT_BITS-1:0] k_q, k_d;
  logic [LVL_W-1:0]      lvl_q, lvl_d;
  logic [FUNC_W-1:0]     func_q, func_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [RANK_W-1:0]     rank_q, rank_d;
  logic [KEY_W-1:0]      found_q, found_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic                  out_valid_q, out_valid_d;
  out_word_t             out_q, out_d;

  // RAM ports
  logic                  ram_we;
  logic [NODE_W-1:0]     ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [NODE_W-1:0]     ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;

  // ALU ports
  logic [AW-1:0]         alu_a, alu_b, alu_sum;
  logic                  alu_sub;
  alu_flags_t            alu_flags;

  // Width adaptation of keys, ranks and counts
  logic [KEY_BITS+KEY_W-1:0]       in_key_wide;
  logic [KEY_BITS-1:0]             in_key;
  logic [AW+COUNT_BITS-1:0]        rd_wide, k_wide, cmax_wide;
  logic [AW+RANK_W-1:0]            rank_wide;
  logic [COUNT_BITS+RANK_W-1:0]    rank_cnt_wide;
  logic [AW-1:0]                   rd_ext, k_ext, cmax_ext, rank_ext;
  logic [COUNT_BITS-1:0]           rank_cnt;
  logic [NODE_W-1:0]               leaf_in, leaf_q;
  logic [NODE_W-1:0]               next_node;
  logic [KEY_BITS+KEY_W-1:0]       found_wide;
  logic                            go_left;

  assign in_key_wide   = {{KEY_BITS{1'b0}}, in_word_i.key};
  assign in_key        = in_key_wide[KEY_BITS-1:0];
  assign rd_wide       = {{AW{1'b0}}, ram_rdata};
  assign rd_ext        = rd_wide[AW-1:0];
  assign k_wide        = {{AW{1'b0}}, k_q};
  assign k_ext         = k_wide[AW-1:0];
  assign cmax_wide     = {{AW{1'b0}}, {COUNT_BITS{1'b1}}};
  assign cmax_ext      = cmax_wide[AW-1:0];
  assign rank_wide     = {{AW{1'b0}}, rank_q};
  assign rank_ext      = rank_wide[AW-1:0];
  assign rank_cnt_wide = {{COUNT_BITS{1'b0}}, rank_q};
  assign rank_cnt      = rank_cnt_wide[COUNT_BITS-1:0];
  assign leaf_in       = {1'b1, in_key};
  assign leaf_q        = {1'b1, key_q};

  // Descent step: go left when k <= left count
  assign go_left    = !alu_flags.carry || alu_flags.zero;
  assign next_node  = {node_q[KEY_BITS-1:0], !go_left};
  assign found_wide = {{KEY_W{1'b0}}, next_node[KEY_BITS-1:0]};

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    node_d      = node_q;
    k_d         = k_q;
    lvl_d       = lvl_q;
    func_d      = func_q;
    key_d       = key_q;
    rank_d      = rank_q;
    found_d     = found_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = node_q;
    ram_wdata   = '0;
    ram_raddr   = ROOT;
    alu_a       = '0;
    alu_b       = '0;
    alu_sub     = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + NODE_W'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          func_d   = in_word_i.func;
          key_d    = in_key;
          rank_d   = in_word_i.rank;
          found_d  = '0;
          status_d = STAT_OK;
          // remove checks its leaf, the others the root
          ram_raddr = (in_word_i.func == FN_REMOVE) ? leaf_in : ROOT;
          state_d   = (in_word_i.func == FN_NOP) ? S_DONE : S_CHECK;
        end
      end

      S_CHECK: begin
        alu_a   = rd_ext;
        alu_sub = 1'b1;
        case (func_q)
          FN_INSERT: begin
            alu_b = cmax_ext;
            if (alu_flags.zero) begin
              status_d = STAT_FULL;
              state_d  = S_DONE;
            end else begin
              ram_raddr = leaf_q;
              node_d    = leaf_q;
              state_d   = S_WALK;
            end
          end
          FN_REMOVE: begin
            alu_b = '0;
            if (alu_flags.zero) begin
              status_d = STAT_ABSENT;
              state_d  = S_DONE;
            end else begin
              ram_raddr = leaf_q;
              node_d    = leaf_q;
              state_d   = S_WALK;
            end
          end
          FN_FIND: begin
            // root - rank borrows when rank exceeds the total
            alu_b = rank_ext;
            if ((rank_q == '0) || !alu_flags.carry) begin
              status_d = STAT_RANK;
              state_d  = S_DONE;
            end else begin
              ram_raddr = ROOT_LC;
              node_d    = ROOT;
              k_d       = rank_cnt;
              lvl_d     = '0;
              state_d   = S_FIND;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_WALK: begin
        // leaf to root: write node +/- 1, fetch its parent
        alu_a     = rd_ext;
        alu_b     = AW'(1);
        alu_sub   = (func_q == FN_REMOVE);
        ram_we    = 1'b1;
        ram_waddr = node_q;
        ram_wdata = alu_sum[COUNT_BITS-1:0];
        ram_raddr = node_q >> 1;
        node_d    = node_q >> 1;
        if (node_q == ROOT) begin
          state_d = S_DONE;
        end
      end

      S_FIND: begin
        // compare k with the left child count, step one level down
        alu_a     = k_ext;
        alu_b     = rd_ext;
        alu_sub   = 1'b1;
        node_d    = next_node;
        ram_raddr = {next_node[KEY_BITS-1:0], 1'b0};
        lvl_d     = lvl_q + LVL_W'(1);
        if (!go_left) begin
          k_d = alu_sum[COUNT_BITS-1:0];
        end
        if (lvl_q == LVL_LAST) begin
          found_d = found_wide[KEY_W-1:0];
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d     = 1'b1;
          out_d.found_key = found_q;
          out_d.status    = status_q;
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    node_q   <= node_d;
    k_q      <= k_d;
    lvl_q    <= lvl_d;
    func_q   <= func_d;
    key_q    <= key_d;
    rank_q   <= rank_d;
    found_q  <= found_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  // Count tree storage
  ostc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_tree (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared add/subtract unit
  ostc_alu #(
    .W (AW)
  ) u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .sum_o   (alu_sum),
    .flags_o (alu_flags)
  );

endmodule : order_statistic_count_tree_core
`default_nettype wire
